// ===== rtl/scp_pkg.sv =====
package scp_pkg;

  localparam int MAX_FIELD_DEF     = 30;
  localparam int KEY_MATCH_LEN_DEF = 5;

  localparam int KW_COUNT   = 10;
  localparam int KW_LEN_MAX = 5;
  localparam int NUM_SLOTS  = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_EQ,
    CLS_SEMI,
    CLS_COMMA,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
  } scp_item_t;

  typedef struct packed {
    logic               head_valid;
    logic               full;
    logic [Q_CNT_W-1:0] count;
  } scp_qstat_t;

  typedef struct packed {
    logic [KW_LEN_MAX*8-1:0] text;
    logic [2:0]              len;
    logic [3:0]              code;
  } kw_t;

  // Keyword text is left-justified: the first character sits in the top byte.
  localparam kw_t KW_TABLE [KW_COUNT] = '{
    '{text: {"id", 24'h0},    len: 3'd2, code: 4'd1},
    '{text: "reset",          len: 3'd5, code: 4'd2},
    '{text: {"r1", 24'h0},    len: 3'd2, code: 4'd3},
    '{text: {"r2", 24'h0},    len: 3'd2, code: 4'd4},
    '{text: {"r3", 24'h0},    len: 3'd2, code: 4'd5},
    '{text: {"r4", 24'h0},    len: 3'd2, code: 4'd6},
    '{text: {"rgb0", 8'h0},   len: 3'd4, code: 4'd7},
    '{text: {"rgb1", 8'h0},   len: 3'd4, code: 4'd8},
    '{text: "rgb_r",          len: 3'd5, code: 4'd9},
    '{text: "rgb_a",          len: 3'd5, code: 4'd10}
  };

  localparam logic [3:0] CODE_INVALID = 4'd0;

  function automatic logic [3:0] key_lookup(input logic [KW_LEN_MAX-1:0][7:0] pfx,
                                            input logic [2:0] len);
    logic [3:0] code;
    logic       same;
    code = CODE_INVALID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      same = (KW_TABLE[k].len == len);
      for (int i = 0; i < KW_LEN_MAX; i++) begin
        if ((3'(i) < len) && (pfx[i] != KW_TABLE[k].text[KW_LEN_MAX*8-1-8*i -: 8])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        code = KW_TABLE[k].code;
      end
    end
    return code;
  endfunction

endpackage

// ===== rtl/scp_front.sv =====
module scp_front (
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  output logic               in_ready,
  input  scp_pkg::scp_qstat_t qstat,
  output logic               push,
  output scp_pkg::scp_item_t  item
);
  import scp_pkg::*;

  byte_cls_t cls;

  always_comb begin
    priority if (in_rx_byte == 8'h3D) begin
      cls = CLS_EQ;
    end else if (in_rx_byte == 8'h3B) begin
      cls = CLS_SEMI;
    end else if (in_rx_byte == 8'h2C) begin
      cls = CLS_COMMA;
    end else if (in_rx_byte == 8'h20 || (in_rx_byte >= 8'h09 && in_rx_byte <= 8'h0D)) begin
      cls = CLS_SPACE;
    end else if (in_rx_byte == 8'h2B) begin
      cls = CLS_PLUS;
    end else if (in_rx_byte == 8'h2D) begin
      cls = CLS_MINUS;
    end else if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_ready  = !qstat.full;
  assign push      = in_valid && !qstat.full;
  assign item.cls  = cls;
  assign item.data = in_rx_byte;

endmodule

// ===== rtl/scp_queue.sv =====
module scp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scp_pkg::scp_item_t  push_item,
  input  logic               pop,
  output scp_pkg::scp_item_t  head_item,
  output scp_pkg::scp_qstat_t qstat
);
  import scp_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  scp_item_t          mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item        = mem[rd_ptr_r];
  assign qstat.head_valid = (cnt_r != '0);
  assign qstat.full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign qstat.count      = cnt_r;

endmodule

// ===== rtl/scp_back.sv =====
module scp_back #(
  parameter int MAX_FIELD     = scp_pkg::MAX_FIELD_DEF,
  parameter int KEY_MATCH_LEN = scp_pkg::KEY_MATCH_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scp_pkg::scp_qstat_t qstat,
  input  scp_pkg::scp_item_t  head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_command_code,
  output logic signed [31:0] out_value_one,
  output logic signed [31:0] out_value_two,
  output logic signed [31:0] out_value_three
);
  import scp_pkg::*;

  localparam int LEN_W = $clog2(MAX_FIELD + 2);
  localparam int IDX_W = $clog2(KEY_MATCH_LEN);

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_NUM  = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  logic [7:0]       key_prefix_r [KEY_MATCH_LEN];
  logic [LEN_W-1:0] key_len_r,  key_len_nxt;
  logic             key_done_r, key_done_nxt;
  logic [2:0]       slot_r,     slot_nxt;
  logic [31:0]      acc_r   [NUM_SLOTS];
  logic [31:0]      acc_nxt [NUM_SLOTS];
  logic [LEN_W-1:0] vlen_r   [NUM_SLOTS];
  logic [LEN_W-1:0] vlen_nxt [NUM_SLOTS];
  logic [1:0]       phase_r   [NUM_SLOTS];
  logic [1:0]       phase_nxt [NUM_SLOTS];
  logic             neg_r   [NUM_SLOTS];
  logic             neg_nxt [NUM_SLOTS];

  logic             out_valid_r;
  logic [3:0]       code_r;
  logic [31:0]      val_r [NUM_SLOTS];

  logic             pfx_we;
  logic             emit;
  logic [1:0]       s;
  logic [LEN_W-1:0] key_len_inc;
  logic [LEN_W-1:0] vlen_inc;
  logic [35:0]      mul10;
  logic [31:0]      acc_step;
  logic [KW_LEN_MAX-1:0][7:0] pfx;
  logic [2:0]       match_len;
  logic [3:0]       code_nxt;
  logic [31:0]      val_nxt [NUM_SLOTS];

  assign pop = qstat.head_valid && (!out_valid_r || out_ready);
  assign s   = 2'(slot_r - 3'd1);

  assign key_len_inc = key_len_r + 1'b1;
  assign vlen_inc    = vlen_r[s] + 1'b1;
  assign mul10       = ({4'h0, acc_r[s]} << 3) + ({4'h0, acc_r[s]} << 1)
                     + {32'h0, head_item.data[3:0]};
  assign acc_step    = (mul10 > {4'h0, MAG_LIMIT}) ? MAG_LIMIT : mul10[31:0];

  always_comb begin
    for (int i = 0; i < KW_LEN_MAX; i++) begin
      pfx[i] = key_prefix_r[i];
    end
    match_len = (key_len_r <= LEN_W'(KW_LEN_MAX)) ? key_len_r[2:0] : 3'd0;
    code_nxt  = key_lookup(pfx, match_len);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (neg_r[i]) begin
        val_nxt[i] = 32'd0 - acc_r[i];
      end else begin
        val_nxt[i] = (acc_r[i] > POS_MAX) ? POS_MAX : acc_r[i];
      end
    end
  end

  always_comb begin
    key_len_nxt  = key_len_r;
    key_done_nxt = key_done_r;
    slot_nxt     = slot_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      acc_nxt[i]   = acc_r[i];
      vlen_nxt[i]  = vlen_r[i];
      phase_nxt[i] = phase_r[i];
      neg_nxt[i]   = neg_r[i];
    end
    pfx_we = 1'b0;
    emit   = 1'b0;

    if (pop) begin
      priority if (head_item.cls == CLS_EQ && key_len_r != '0) begin
        key_done_nxt = 1'b1;
      end else if (head_item.cls == CLS_SEMI) begin
        emit = (vlen_r[0] != '0) && (key_len_r != '0);
      end else if (head_item.cls == CLS_COMMA) begin
        if (slot_r < 3'd4) begin
          slot_nxt = slot_r + 3'd1;
        end
      end else if (!key_done_r) begin
        pfx_we      = (key_len_r < LEN_W'(KEY_MATCH_LEN));
        key_len_nxt = key_len_inc;
      end else if (slot_r >= 3'd1 && slot_r <= 3'd3) begin
        vlen_nxt[s] = vlen_inc;
        if (phase_r[s] == PH_SKIP) begin
          if (head_item.cls != CLS_SPACE) begin
            phase_nxt[s] = PH_NUM;
            if (head_item.cls == CLS_PLUS || head_item.cls == CLS_MINUS) begin
              neg_nxt[s] = (head_item.cls == CLS_MINUS);
            end else if (head_item.cls == CLS_DIGIT) begin
              acc_nxt[s] = acc_step;
            end else begin
              phase_nxt[s] = PH_STOP;
            end
          end
        end else if (phase_r[s] == PH_NUM) begin
          if (head_item.cls == CLS_DIGIT) begin
            acc_nxt[s] = acc_step;
          end else begin
            phase_nxt[s] = PH_STOP;
          end
        end
      end else begin
        // Bytes for a value slot past the third are dropped.
      end

      // A semicolon or an overlong field returns the parser to its idle state.
      if (head_item.cls == CLS_SEMI
          || (key_len_nxt > LEN_W'(MAX_FIELD))
          || (slot_r <= 3'd3 && vlen_nxt[s] > LEN_W'(MAX_FIELD))) begin
        key_len_nxt  = '0;
        key_done_nxt = 1'b0;
        slot_nxt     = 3'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          acc_nxt[i]   = '0;
          vlen_nxt[i]  = '0;
          phase_nxt[i] = PH_SKIP;
          neg_nxt[i]   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= '0;
      key_done_r  <= 1'b0;
      slot_r      <= 3'd1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        acc_r[i]   <= '0;
        vlen_r[i]  <= '0;
        phase_r[i] <= PH_SKIP;
        neg_r[i]   <= 1'b0;
      end
    end else begin
      key_len_r  <= key_len_nxt;
      key_done_r <= key_done_nxt;
      slot_r     <= slot_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        acc_r[i]   <= acc_nxt[i];
        vlen_r[i]  <= vlen_nxt[i];
        phase_r[i] <= phase_nxt[i];
        neg_r[i]   <= neg_nxt[i];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pfx_we) begin
      key_prefix_r[key_len_r[IDX_W-1:0]] <= head_item.data;
    end
    if (emit) begin
      code_r <= code_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        val_r[i] <= val_nxt[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_code = code_r;
  assign out_value_one    = val_r[0];
  assign out_value_two    = val_r[1];
  assign out_value_three  = val_r[2];

endmodule

// ===== rtl/serial_command_parser_unit.sv =====
// Channel  | Direction | Ports
// ---------+-----------+------------------------------------------------------------
// in       | input     | in_valid, in_ready, in_rx_byte
// out      | output    | out_valid, out_ready, out_command_code, out_value_one/two/three
//
// One byte is taken per cycle while in_ready is high; the back end retires one queued byte
// per cycle unless a result is held; a result is registered the cycle after its ';' retires.
// The front classifies a byte in the cycle it is accepted; a two-entry queue feeds the back.
// Reset is synchronous and active low; it clears the queue, the parser and out_valid.
// The back stalls only while a result waits in the output register; the queue then fills
// and in_ready drops once both entries are held.
module serial_command_parser_unit #(
  parameter int MAX_FIELD     = scp_pkg::MAX_FIELD_DEF,
  parameter int KEY_MATCH_LEN = scp_pkg::KEY_MATCH_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_command_code,
  output logic signed [31:0] out_value_one,
  output logic signed [31:0] out_value_two,
  output logic signed [31:0] out_value_three
);
  import scp_pkg::*;

  scp_qstat_t qstat;
  scp_item_t  push_item;
  scp_item_t  head_item;
  logic       push;
  logic       pop;

  scp_front u_front (
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .qstat      (qstat),
    .push       (push),
    .item       (push_item)
  );

  scp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  scp_back #(
    .MAX_FIELD     (MAX_FIELD),
    .KEY_MATCH_LEN (KEY_MATCH_LEN)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qstat            (qstat),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_value_one    (out_value_one),
    .out_value_two    (out_value_two),
    .out_value_three  (out_value_three)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("Queue holds more items than it has entries.");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!out_valid || out_ready))
    else $error("Back end retired an item while a result was still held.");

  a_result_from_semicolon: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && head_item.cls == CLS_SEMI))
    else $error("A result appeared without a semicolon being retired.");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.full && !pop) |=> !qstat.head_valid || qstat.full || $past(pop))
    else $error("Queue lost an item while full.");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import scp_pkg::*;

  typedef enum logic [3:0] {
    CMD_INVALID, CMD_ID, CMD_RESET, CMD_RELAY1, CMD_RELAY2, CMD_RELAY3, CMD_RELAY4,
    CMD_RGB0, CMD_RGB1, CMD_RGB_R, CMD_RGB_A
  } cmd_code_e;

  typedef enum int {PH_SKIP, PH_DIGITS, PH_STOPPED} num_phase_e;

  typedef struct {
    logic [3:0]         code;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] v3;
  } cmd_result_t;

  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam int FIELD_MAX   = MAX_FIELD_DEF;
  localparam int PREFIX_LEN  = KEY_MATCH_LEN_DEF;
  localparam logic [63:0] MAG_CAP = 64'd2147483648;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_command_code;
  logic signed [31:0] out_value_one;
  logic signed [31:0] out_value_two;
  logic signed [31:0] out_value_three;

  serial_command_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_value_one    (out_value_one),
    .out_value_two    (out_value_two),
    .out_value_three  (out_value_three)
  );

  string kw_names [10] = '{"id", "reset", "r1", "r2", "r3", "r4",
                           "rgb0", "rgb1", "rgb_r", "rgb_a"};

  // Parser state mirrored by the testbench.
  logic [7:0]  key_bytes [PREFIX_LEN];
  int unsigned key_len;
  bit          key_closed;
  int unsigned slot_idx;
  logic [31:0] val_mag [3];
  int unsigned val_len [3];
  num_phase_e  val_phase [3];
  bit          val_neg [3];

  cmd_result_t pending_cmds [$];
  cmd_result_t head_cmd;

  int fail_count;
  int cycle_count;
  int sent_bytes;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;

  function automatic void clear_parse();
    key_len    = 0;
    key_closed = 1'b0;
    slot_idx   = 1;
    for (int i = 0; i < 3; i++) begin
      val_mag[i]   = '0;
      val_len[i]   = 0;
      val_phase[i] = PH_SKIP;
      val_neg[i]   = 1'b0;
    end
  endfunction

  function automatic logic [3:0] keyword_code();
    logic [39:0] p;
    p = '0;
    if (key_len > PREFIX_LEN) return CMD_INVALID;
    for (int i = 0; i < key_len; i++) p[39-8*i -: 8] = key_bytes[i];
    case (key_len)
      2: begin
        case (p[39:24])
          "id":    return CMD_ID;
          "r1":    return CMD_RELAY1;
          "r2":    return CMD_RELAY2;
          "r3":    return CMD_RELAY3;
          "r4":    return CMD_RELAY4;
          default: return CMD_INVALID;
        endcase
      end
      4: begin
        case (p[39:8])
          "rgb0":  return CMD_RGB0;
          "rgb1":  return CMD_RGB1;
          default: return CMD_INVALID;
        endcase
      end
      5: begin
        case (p)
          "reset": return CMD_RESET;
          "rgb_r": return CMD_RGB_R;
          "rgb_a": return CMD_RGB_A;
          default: return CMD_INVALID;
        endcase
      end
      default: return CMD_INVALID;
    endcase
  endfunction

  function automatic logic signed [31:0] decoded_value(int s);
    if (val_neg[s]) return 32'd0 - val_mag[s];
    return (val_mag[s] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : val_mag[s];
  endfunction

  function automatic void take_value_byte(int s, logic [7:0] c);
    logic [63:0] m;
    val_len[s]++;
    if (val_phase[s] == PH_STOPPED) return;
    if (val_phase[s] == PH_SKIP) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      val_phase[s] = PH_DIGITS;
      if (c == CH_PLUS || c == CH_MINUS) begin
        val_neg[s] = (c == CH_MINUS);
        return;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      m = 64'(val_mag[s]) * 10 + 64'(c - CH_ZERO);
      if (m > MAG_CAP) m = MAG_CAP;
      val_mag[s] = m[31:0];
    end else begin
      val_phase[s] = PH_STOPPED;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    cmd_result_t r;
    int s;
    if (c == CH_EQ && key_len > 0) begin
      key_closed = 1'b1;
    end else if (c == CH_SEMI) begin
      if (val_len[0] > 0 && key_len > 0) begin
        r.code = keyword_code();
        r.v1   = decoded_value(0);
        r.v2   = decoded_value(1);
        r.v3   = decoded_value(2);
        pending_cmds.push_back(r);
      end
      clear_parse();
    end else if (c == CH_COMMA) begin
      if (slot_idx < 4) slot_idx++;
    end else if (!key_closed) begin
      if (key_len < PREFIX_LEN) key_bytes[key_len] = c;
      key_len++;
      if (key_len > FIELD_MAX) clear_parse();
    end else if (slot_idx <= 3) begin
      s = slot_idx - 1;
      take_value_byte(s, c);
      if (val_len[s] > FIELD_MAX) clear_parse();
    end
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_EQ || c == CH_SEMI || c == CH_COMMA);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = c;
    do @(posedge clk); while (!in_ready);
    parse_byte(c);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_random_command();
    logic [7:0] seq [$];
    string kw;
    int pick;
    int nvals;
    int ndig;
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) == 1) seq.push_back(CH_SEMI);
    end else begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        kw = kw_names[$urandom_range(9)];
        for (int i = 0; i < kw.len(); i++) seq.push_back(kw[i]);
        if (pick >= 60) seq[seq.size()-1] = plain_byte();
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 7)) seq.push_back(plain_byte());
      end else begin
        repeat (FIELD_MAX + $urandom_range(1, 3)) seq.push_back("k");
      end
      if ($urandom_range(19) != 0) seq.push_back(CH_EQ);
      nvals = $urandom_range(0, 5);
      for (int v = 0; v < nvals; v++) begin
        if (v > 0) seq.push_back(CH_COMMA);
        if ($urandom_range(29) == 0) begin
          repeat (FIELD_MAX + 1 + $urandom_range(2)) begin
            seq.push_back(8'(CH_ZERO + $urandom_range(9)));
          end
        end else begin
          if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 2)) begin
              seq.push_back(($urandom_range(5) == 5) ? CH_SPACE
                                                     : 8'(CH_TAB + $urandom_range(4)));
            end
          end
          pick = $urandom_range(4);
          if (pick == 0) seq.push_back(CH_PLUS);
          if (pick == 1) seq.push_back(CH_MINUS);
          pick = $urandom_range(9);
          ndig = (pick < 1) ? 0 : (pick < 7) ? $urandom_range(1, 4) : $urandom_range(9, 12);
          repeat (ndig) seq.push_back(8'(CH_ZERO + $urandom_range(9)));
          if ($urandom_range(6) == 0) begin
            seq.push_back(plain_byte());
            if ($urandom_range(1) == 1) seq.push_back(8'(CH_ZERO + $urandom_range(9)));
          end
        end
      end
      seq.push_back(CH_SEMI);
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_text("==1;");
    send_text("id=-3000000000,+5x,,9;");
    send_text("x=;");
    send_byte(8'hFF);
    send_byte(CH_EQ);
    send_byte(8'h00);
    send_byte(CH_SEMI);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int nbytes);
    int target;
    target      = sent_bytes + nbytes;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent_bytes < target) send_random_command();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = 120;
    for (int i = 0; i < 12; i++) send_text($sformatf("r%0d=%0d;", 1 + i % 4, i));
  endtask

  task automatic finish_run();
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_command_parser_unit verification clean");
    end else begin
      $display("serial_command_parser_unit verification failed");
    end
    $finish;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_cmds.size());
      $display("serial_command_parser_unit verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result: code %0d values %0d %0d %0d", out_command_code,
                   out_value_one, out_value_two, out_value_three);
        end
      end else begin
        head_cmd = pending_cmds.pop_front();
        if (out_command_code !== head_cmd.code || out_value_one !== head_cmd.v1 ||
            out_value_two !== head_cmd.v2 || out_value_three !== head_cmd.v3) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch: expected code %0d values %0d %0d %0d", head_cmd.code,
                     head_cmd.v1, head_cmd.v2, head_cmd.v3);
            $display("          actual   code %0d values %0d %0d %0d", out_command_code,
                     out_value_one, out_value_two, out_value_three);
          end
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    out_ready   = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    sent_bytes  = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = 0;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(15, 49, 285);
    test_random(49, 15, 285);
    test_random(0, 0, 285);
    test_backpressure();
    finish_run();
  end

endmodule
